>>> rtl/core/tbsa_pkg.sv
// Shared constants, types and encoder functions of the two-level bitmap slot allocator.
package tbsa_pkg;

   localparam int LEAVES_PER_BRANCH = 64;
   localparam int MAX_BRANCHES      = 16;
   localparam int BRANCH_W          = 4;
   localparam int LEAF_W            = 6;
   localparam int COUNT_W           = 7;
   localparam int CFG_W             = 5;
   localparam int CSR_DATA_W        = 8;
   localparam int ENTRY_W           = LEAVES_PER_BRANCH + COUNT_W;
   localparam int REQ_DATA_W        = 16;
   localparam int RSP_DATA_W        = 24;

   localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(MAX_BRANCHES);
   localparam logic [COUNT_W-1:0] COUNT_FULL   = COUNT_W'(LEAVES_PER_BRANCH);

   typedef logic [LEAVES_PER_BRANCH-1:0] leaf_vec_type;
   typedef logic [MAX_BRANCHES-1:0]      branch_vec_type;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_FULL        = 2'd1,
      STATUS_BAD_RELEASE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_READ   = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      logic                en;
      logic [BRANCH_W-1:0] branch;
      logic                nonfull;
   } map_upd_type;

   typedef struct packed {
      logic                any;
      logic [BRANCH_W-1:0] pick;
      logic [CFG_W-1:0]    active;
      branch_vec_type      entry_valid;
   } map_stat_type;

   function automatic logic [LEAF_W-1:0] lowest_leaf(input leaf_vec_type v);
      logic [LEAF_W-1:0] idx;
      idx = '0;
      for (int i = LEAVES_PER_BRANCH - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = LEAF_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [BRANCH_W-1:0] lowest_branch(input branch_vec_type v);
      logic [BRANCH_W-1:0] idx;
      idx = '0;
      for (int i = MAX_BRANCHES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BRANCH_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/core/two_level_bitmap_slot_allocator_top.sv
// Top level of the two-level bitmap slot allocator: sequencer and read-modify-write datapath.
// Per request, the transfer cycle picks the branch (an acquire from the per-branch nonfull
// flags, a release from the request), the read state reads the branch entry (bitmap and free
// count) from the entry memory, and the update state, once the result register is free, finds
// the lowest free leaf or clears the released one, writes the entry back and loads the result
// register. A new request is taken while the previous result still waits in its output
// register. No clearing pass exists: reset and every csr write mark all entries as
// untouched through per-branch valid flags, and an untouched entry reads as all leaves free.
module two_level_bitmap_slot_allocator_top
   import tbsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_DATA_W-1:0] csr_data,   // [4:0] active_branches
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] slot_branch, [9:4] slot_leaf
   input  logic [0:0]            req_tuser,  // [0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [3:0] granted_branch, [9:4] granted_leaf,
                                             // [16:10] branch_free_after
   output logic [1:0]            rsp_tuser   // [1:0] status
);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [BRANCH_W-1:0] branch_ff, branch_in;
   logic [LEAF_W-1:0]   leaf_ff, leaf_in;
   logic                miss_ff, miss_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [BRANCH_W-1:0] gbranch_ff, gbranch_in;
   logic [LEAF_W-1:0]   gleaf_ff, gleaf_in;
   logic [COUNT_W-1:0]  free_after_ff, free_after_in;

   map_stat_type        stat;
   map_upd_type         upd;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ENTRY_W-1:0]  wr_data;
   logic                wr_en;

   logic                req_fire;
   logic                csr_fire;
   logic                slot_free;
   logic                fire;
   logic                in_range;
   logic                cur_valid;
   leaf_vec_type        cur_map;
   logic [COUNT_W-1:0]  cur_cnt;
   logic [LEAF_W-1:0]   pick_leaf;
   logic                hit;
   leaf_vec_type        new_map;
   logic [COUNT_W-1:0]  new_cnt;

   tbsa_branch_map u_map (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_fire),
      .csr_value (csr_data),
      .upd       (upd),
      .stat      (stat)
   );

   tbsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BRANCHES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (branch_ff),
      .wr_data (wr_data),
      .rd_addr (branch_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign fire       = (state_ff == ST_UPDATE) && slot_free;

   assign in_range = (CFG_W'(req_tdata[BRANCH_W-1:0]) < stat.active) &&
                     (COUNT_W'(req_tdata[BRANCH_W+LEAF_W-1:BRANCH_W]) < COUNT_FULL);

   assign cur_valid = stat.entry_valid[branch_ff];
   assign cur_map   = cur_valid ? rd_data[LEAVES_PER_BRANCH-1:0] : '0;
   assign cur_cnt   = cur_valid ? rd_data[ENTRY_W-1:LEAVES_PER_BRANCH] : COUNT_FULL;
   assign pick_leaf = lowest_leaf(~cur_map);
   assign hit       = cur_map[leaf_ff];

   always_comb begin
      if (op_ff == OP_ACQUIRE) begin
         new_map = cur_map | (leaf_vec_type'(1) << pick_leaf);
         new_cnt = cur_cnt - COUNT_W'(1);
      end else begin
         new_map = cur_map & ~(leaf_vec_type'(1) << leaf_ff);
         new_cnt = (cur_cnt < COUNT_FULL) ? cur_cnt + COUNT_W'(1) : cur_cnt;
      end
   end

   assign wr_en       = fire && !miss_ff && ((op_ff == OP_ACQUIRE) || hit);
   assign wr_data     = {new_cnt, new_map};
   assign upd.en      = wr_en;
   assign upd.branch  = branch_ff;
   assign upd.nonfull = (new_cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      branch_ff     <= branch_in;
      leaf_ff       <= leaf_in;
      miss_ff       <= miss_in;
      status_ff     <= status_in;
      gbranch_ff    <= gbranch_in;
      gleaf_ff      <= gleaf_in;
      free_after_ff <= free_after_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      branch_in     = branch_ff;
      leaf_in       = leaf_ff;
      miss_in       = miss_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      gbranch_in    = gbranch_ff;
      gleaf_in      = gleaf_ff;
      free_after_in = free_after_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = op_type'(req_tuser[0]);
               leaf_in = req_tdata[BRANCH_W+LEAF_W-1:BRANCH_W];
               if (op_type'(req_tuser[0]) == OP_ACQUIRE) begin
                  branch_in = stat.pick;
                  miss_in   = !stat.any;
               end else begin
                  branch_in = req_tdata[BRANCH_W-1:0];
                  miss_in   = !in_range;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (fire) begin
               rsp_valid_in  = 1'b1;
               gbranch_in    = '0;
               gleaf_in      = '0;
               free_after_in = wr_en ? new_cnt : '0;
               if (op_ff == OP_ACQUIRE) begin
                  if (miss_ff) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in  = STATUS_DONE;
                     gbranch_in = branch_ff;
                     gleaf_in   = pick_leaf;
                  end
               end else begin
                  status_in = (miss_ff || !hit) ? STATUS_BAD_RELEASE : STATUS_DONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BRANCH_W - LEAF_W - COUNT_W){1'b0}},
                        free_after_ff, gleaf_ff, gbranch_ff};
   assign rsp_tuser  = status_ff;

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UPDATE))
      else $error("entry write outside update state");

   a_grant_has_free: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (op_ff == OP_ACQUIRE)) |-> (cur_cnt != '0) && !cur_map[pick_leaf])
      else $error("acquire picked a branch or leaf with nothing free");

   a_grant_active: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (op_ff == OP_ACQUIRE)) |-> (CFG_W'(branch_ff) < stat.active))
      else $error("acquire granted an inactive branch");

   a_result_follows_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE))
      else $error("result loaded outside update state");

endmodule

>>> rtl/core/tbsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tbsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tbsa_branch_map.sv
// Branch summary: active count, entry valid flags, nonfull flags and first-branch pick.
module tbsa_branch_map
   import tbsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_DATA_W-1:0] csr_value,
   input  map_upd_type           upd,
   output map_stat_type          stat
);

   logic [CFG_W-1:0] active_ff;
   branch_vec_type   valid_ff;
   branch_vec_type   nonfull_ff;
   branch_vec_type   live;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_RESET;
         valid_ff   <= '0;
         nonfull_ff <= '1;
      end else if (csr_write) begin
         active_ff  <= csr_value[CFG_W-1:0];
         valid_ff   <= '0;
         nonfull_ff <= '1;
      end else if (upd.en) begin
         valid_ff[upd.branch]   <= 1'b1;
         nonfull_ff[upd.branch] <= upd.nonfull;
      end
   end

   always_comb begin
      for (int b = 0; b < MAX_BRANCHES; b++) begin
         live[b] = nonfull_ff[b] && (CFG_W'(b) < active_ff);
      end
   end

   assign stat.any         = |live;
   assign stat.pick        = lowest_branch(live);
   assign stat.active      = active_ff;
   assign stat.entry_valid = valid_ff;

endmodule
